// ===== rtl/core/iirdf2_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_pkg
// Shared widths, register indexes and controller/datapath command types for
// the Direct Form II biquad.
// ----------------------------------------------------------------------------
package iirdf2_pkg;

    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int ACC_W         = PROD_W + 2;   // three full products never overflow
    localparam int CFG_IDX_W     = 3;
    localparam int TERM_W        = 2;
    localparam int DEFAULT_ORDER = 2;

    localparam logic signed [DATA_W-1:0] FB_COEF_0_RST  = 32'sh4000_0000;
    localparam logic signed [DATA_W-1:0] LEVEL_GAIN_RST = 32'sh0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FB_COEF_0  = 3'd0,
        CFG_FB_COEF_1  = 3'd1,
        CFG_FB_COEF_2  = 3'd2,
        CFG_FF_COEF_0  = 3'd3,
        CFG_FF_COEF_1  = 3'd4,
        CFG_FF_COEF_2  = 3'd5,
        CFG_LEVEL_GAIN = 3'd6,
        CFG_ENABLED    = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        MSEL_FB = 2'd0,
        MSEL_FF = 2'd1,
        MSEL_LV = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic              capture_x;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic [TERM_W-1:0] term;
        logic              first;
        logic              w_load;
        logic              y_load;
        logic              lvl_load;
        logic              zero_load;
    } cmd_t;

    typedef struct packed {
        logic enabled;
        logic out_full;
    } status_t;

endpackage

// ===== rtl/core/iirdf2_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_in_if
// Request channel into the biquad: function select and sample/level value.
// ----------------------------------------------------------------------------
interface iirdf2_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

// ===== rtl/core/iirdf2_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_out_if
// Result channel out of the biquad: one filtered sample per filter request.
// ----------------------------------------------------------------------------
interface iirdf2_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

// ===== rtl/core/iirdf2_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_datapath
// Coefficient registers, delay line, shared 32x32 multiplier, accumulator,
// round/saturate and the output register.
// ----------------------------------------------------------------------------
module iirdf2_datapath #(
    parameter int ORDER = iirdf2_pkg::DEFAULT_ORDER
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  iirdf2_pkg::cmd_t                      cmd,
    output iirdf2_pkg::status_t                   status,
    input  logic signed [iirdf2_pkg::DATA_W-1:0]  value,
    input  logic                                  cfg_we,
    input  logic [iirdf2_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iirdf2_pkg::DATA_W-1:0]         cfg_data,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic signed [iirdf2_pkg::DATA_W-1:0]  filtered
);
    import iirdf2_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(32'sh8000_0000);

    // round half up at bit s, then clamp to signed 32 bits
    function automatic logic signed [DATA_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc,
        input int unsigned             s
    );
        logic signed [ACC_W-1:0] t;
        begin
            t = acc + (ACC_W'(1) << (s - 1));
            t = t >>> s;
            if (t > SAT_MAX)
                round_sat = SAT_MAX[DATA_W-1:0];
            else if (t < SAT_MIN)
                round_sat = SAT_MIN[DATA_W-1:0];
            else
                round_sat = t[DATA_W-1:0];
        end
    endfunction

    logic signed [DATA_W-1:0] fb_coef_reg [3];
    logic signed [DATA_W-1:0] ff_coef_reg [3];
    logic signed [DATA_W-1:0] level_gain_reg;
    logic                     enabled_reg;
    logic signed [DATA_W-1:0] dl_reg [ORDER];
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] w_reg;
    logic signed [PROD_W-1:0] product_reg;
    logic signed [PROD_W-1:0] product_next;
    logic                     prod_valid_reg;
    logic                     prod_first_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] filtered_reg;

    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    logic signed [DATA_W-1:0] tap_op;
    logic signed [DATA_W-1:0] rnd30;
    logic signed [DATA_W-1:0] rnd16;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_coef_reg[0] <= FB_COEF_0_RST;
            fb_coef_reg[1] <= '0;
            fb_coef_reg[2] <= '0;
            ff_coef_reg[0] <= '0;
            ff_coef_reg[1] <= '0;
            ff_coef_reg[2] <= '0;
            level_gain_reg <= LEVEL_GAIN_RST;
            enabled_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FB_COEF_0:  fb_coef_reg[0] <= cfg_data;
                CFG_FB_COEF_1:  fb_coef_reg[1] <= cfg_data;
                CFG_FB_COEF_2:  fb_coef_reg[2] <= cfg_data;
                CFG_FF_COEF_0:  ff_coef_reg[0] <= cfg_data;
                CFG_FF_COEF_1:  ff_coef_reg[1] <= cfg_data;
                CFG_FF_COEF_2:  ff_coef_reg[2] <= cfg_data;
                CFG_LEVEL_GAIN: level_gain_reg <= cfg_data;
                CFG_ENABLED:    enabled_reg    <= cfg_data[0];
                default:        enabled_reg    <= enabled_reg;
            endcase
        end
    end

    // term 1 reads w[n-1], term 2 reads w[n-2]
    assign tap_op = (cmd.term == TERM_W'(1)) ? dl_reg[0] : dl_reg[ORDER-1];

    always_comb
    begin
        op_a = x_reg;
        op_b = level_gain_reg;
        case (cmd.mul_sel)
            MSEL_FB:
            begin
                case (cmd.term)
                    TERM_W'(0): op_a = fb_coef_reg[0];
                    TERM_W'(1): op_a = fb_coef_reg[1];
                    default:    op_a = fb_coef_reg[2];
                endcase
                op_b = (cmd.term == '0) ? x_reg : tap_op;
            end
            MSEL_FF:
            begin
                case (cmd.term)
                    TERM_W'(0): op_a = ff_coef_reg[0];
                    TERM_W'(1): op_a = ff_coef_reg[1];
                    default:    op_a = ff_coef_reg[2];
                endcase
                op_b = (cmd.term == '0) ? w_reg : tap_op;
            end
            default:
            begin
                op_a = x_reg;
                op_b = level_gain_reg;
            end
        endcase
    end

    assign product_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        if (cmd.capture_x)
            x_reg <= value;
        if (cmd.mul_en)
            product_reg <= product_next;
        if (prod_valid_reg)
            acc_reg <= prod_first_reg ? ACC_W'(product_reg)
                                      : acc_reg + ACC_W'(product_reg);
        if (cmd.w_load)
            w_reg <= rnd30;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_first_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= cmd.mul_en;
            prod_first_reg <= cmd.first;
        end
    end

    assign rnd30 = round_sat(acc_reg, 30);
    assign rnd16 = round_sat(acc_reg, 16);

    // delay line: level preset fills every tap, a sample shifts w in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ORDER; i++)
                dl_reg[i] <= '0;
        end
        else if (cmd.lvl_load)
        begin
            for (int i = 0; i < ORDER; i++)
                dl_reg[i] <= rnd16;
        end
        else if (cmd.y_load)
        begin
            dl_reg[0] <= w_reg;
            for (int i = 1; i < ORDER; i++)
                dl_reg[i] <= dl_reg[i-1];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.y_load || cmd.zero_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.y_load)
            filtered_reg <= rnd30;
        else if (cmd.zero_load)
            filtered_reg <= '0;
    end

    assign out_valid       = out_valid_reg;
    assign filtered        = filtered_reg;
    assign status.enabled  = enabled_reg;
    assign status.out_full = out_valid_reg;

endmodule

// ===== rtl/core/iirdf2_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_ctrl
// Sequencer: steps the shared multiplier through the feedback terms, the
// feedforward terms or the level product, and issues round/load commands.
// ----------------------------------------------------------------------------
module iirdf2_ctrl #(
    parameter int ORDER = iirdf2_pkg::DEFAULT_ORDER
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_func,
    output logic                in_ready,
    input  iirdf2_pkg::status_t status,
    output iirdf2_pkg::cmd_t    cmd
);
    import iirdf2_pkg::*;

    localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(ORDER);

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_FB_MUL  = 11'b000_0000_0010,
        ST_FB_WAIT = 11'b000_0000_0100,
        ST_FB_RND  = 11'b000_0000_1000,
        ST_FF_MUL  = 11'b000_0001_0000,
        ST_FF_WAIT = 11'b000_0010_0000,
        ST_FF_RND  = 11'b000_0100_0000,
        ST_LV_MUL  = 11'b000_1000_0000,
        ST_LV_WAIT = 11'b001_0000_0000,
        ST_LV_RND  = 11'b010_0000_0000,
        ST_ZERO    = 11'b100_0000_0000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [TERM_W-1:0] term_reg;
    logic [TERM_W-1:0] term_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.term   = term_reg;
        cmd.first  = (term_reg == '0);

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                term_next = '0;
                if (in_valid)
                begin
                    cmd.capture_x = 1'b1;
                    if (in_func)
                        state_next = ST_LV_MUL;
                    else if (status.enabled)
                        state_next = ST_FB_MUL;
                    else
                        state_next = ST_ZERO;
                end
            end
            ST_FB_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_FB;
                if (term_reg == LAST_TERM)
                    state_next = ST_FB_WAIT;
                else
                    term_next = term_reg + 1'b1;
            end
            ST_FB_WAIT:
                state_next = ST_FB_RND;
            ST_FB_RND:
            begin
                cmd.w_load = 1'b1;
                term_next  = '0;
                state_next = ST_FF_MUL;
            end
            ST_FF_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_FF;
                if (term_reg == LAST_TERM)
                    state_next = ST_FF_WAIT;
                else
                    term_next = term_reg + 1'b1;
            end
            ST_FF_WAIT:
                state_next = ST_FF_RND;
            ST_FF_RND:
            begin
                if (!status.out_full)
                begin
                    cmd.y_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LV_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_LV;
                cmd.first   = 1'b1;
                state_next  = ST_LV_WAIT;
            end
            ST_LV_WAIT:
                state_next = ST_LV_RND;
            ST_LV_RND:
            begin
                cmd.lvl_load = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_ZERO:
            begin
                if (!status.out_full)
                begin
                    cmd.zero_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/iir_direct_form_two_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_direct_form_two_filter
// Second-order Direct Form II IIR filter, Q16.16 samples, Q2.30 coefficients.
//
// Usage:
//   in_chan  : request with func (0 = filter sample, 1 = preset delay line to
//              value * level_gain) and value. Accepted on valid && ready.
//   out_chan : one filtered sample per func 0 request, none for func 1.
//   cfg_*    : write-only register port, one write per cycle with cfg_we.
// Sequence (one shared 32x32 multiplier, one product per cycle while multiplying):
//   filter sample : feedback products, wait, round into w, feedforward products,
//                   wait, result load (held while the output is full), then idle.
//   level preset  : level product, wait, delay line load, then idle.
//   disabled      : zero result load (held while the output is full), then idle.
// The feedback sum must finish before the feedforward sum starts, and the
// next sample needs the updated delay line, so one request is in flight.
// Reset clears the delay line and loads the register defaults. A finished
// result sits in the output register; if the receiver stalls, a following
// request is still accepted and processed, holding only at its result load.
// ----------------------------------------------------------------------------
module iir_direct_form_two_filter #(
    parameter int ORDER = iirdf2_pkg::DEFAULT_ORDER
) (
    input  logic                                clk,
    input  logic                                rst_n,
    iirdf2_in_if.sink                           in_chan,
    iirdf2_out_if.source                        out_chan,
    input  logic                                cfg_we,
    input  logic [iirdf2_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [iirdf2_pkg::DATA_W-1:0]       cfg_data
);
    import iirdf2_pkg::*;

    cmd_t    cmd;
    status_t status;

    iirdf2_ctrl #(
        .ORDER (ORDER)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_chan.valid),
        .in_func  (in_chan.func),
        .in_ready (in_chan.ready),
        .status   (status),
        .cmd      (cmd)
    );

    iirdf2_datapath #(
        .ORDER (ORDER)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (in_chan.value),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_chan.ready),
        .out_valid (out_chan.valid),
        .filtered  (out_chan.filtered)
    );

endmodule

// ===== rtl/core/iirdf2_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirdf2_checker
// Port-level checks on request sequencing and result hand-off.
// ----------------------------------------------------------------------------
module iirdf2_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_func,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] filtered
);

    // one request in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while previous one in progress");

    // level preset takes multiply, accumulate and round steps
    a_level_duration: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_func) |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("level preset finished too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(filtered)))
        else $error("stalled result changed or dropped");

    a_out_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result withdrawn without being taken");

endmodule

bind iir_direct_form_two_filter iirdf2_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_func   (in_chan.func),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .filtered  (out_chan.filtered)
);
